>>> sv/urfi_pkg.sv
// Package with the shared types and constants of the UART register block.
package urfi_pkg;

  // Receive FIFO storage depth and the widths derived from it.
  localparam int FIFO_SLOTS = 256;
  localparam int FIFO_AW    = $clog2(FIFO_SLOTS);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // Ring size register width and its reset value.
  localparam int QSIZE_W = 9;
  localparam logic [QSIZE_W-1:0] QSIZE_RESET = 9'd16;

  // Width wide enough for both the ring size and the FIFO fill count.
  localparam int CAP_W = (FIFO_CW > QSIZE_W) ? FIFO_CW : QSIZE_W;

  // Request kinds on the input channel.
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_RX    = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Register word offsets.
  localparam logic [3:0] REG_LINE_CTRL  = 4'd0;
  localparam logic [3:0] REG_UART_CTRL  = 4'd1;
  localparam logic [3:0] REG_FIFO_CTRL  = 4'd2;
  localparam logic [3:0] REG_MODEM_CTRL = 4'd3;
  localparam logic [3:0] REG_TRX_STAT   = 4'd4;
  localparam logic [3:0] REG_ERR_STAT   = 4'd5;
  localparam logic [3:0] REG_FIFO_STAT  = 4'd6;
  localparam logic [3:0] REG_MODEM_STAT = 4'd7;
  localparam logic [3:0] REG_TX_DATA    = 4'd8;
  localparam logic [3:0] REG_RX_DATA    = 4'd9;
  localparam logic [3:0] REG_BAUD_DIV   = 4'd10;
  localparam logic [3:0] REG_DIV_SLOT   = 4'd11;
  localparam logic [3:0] REG_INT_PEND   = 4'd12;
  localparam logic [3:0] REG_INT_SRC    = 4'd13;
  localparam logic [3:0] REG_INT_MASK   = 4'd14;

  // Interrupt bits.
  localparam logic [31:0] INT_RXD = 32'h1;
  localparam logic [31:0] INT_ERR = 32'h2;
  localparam logic [31:0] INT_TXD = 32'h4;

  // Status bits of the TX/RX status register.
  localparam logic [2:0] ST_READY  = 3'b001;
  localparam logic [2:0] ST_TXIDLE = 3'b110;
  localparam logic [2:0] ST_RESET  = 3'b110;

  // FIFO control bits: enable, and the two self-clearing reset bits.
  localparam logic [31:0] FCTRL_EN       = 32'h1;
  localparam logic [31:0] FCTRL_RX_RESET = 32'h2;
  localparam logic [31:0] FCTRL_SC_MASK  = 32'h6;

  // Fixed read values.
  localparam logic [31:0] MODEM_STAT_VAL = 32'h1;

endpackage

>>> sv/uart_regs_rx_fifo_irq_unit.sv
// Top level of the UART register block with receive FIFO and interrupt line.
//
// One request (bus read, bus write or received byte) is taken every clock
// cycle, and its result appears in the output register the cycle after it
// is taken. All control registers update at the accepting edge; the receive
// bytes live in a single-port-write, registered-read memory of FIFO_SLOTS
// bytes, and a pop reads the head entry at the accepting edge so the byte
// is available together with the rest of the result. The input stalls only
// while a result is held and the output is stalled. The receive memory is
// not cleared after reset; the fill count tracks which entries hold data.
module uart_regs_rx_fifo_irq_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input request channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_req_type,
  input  logic [3:0]                       in_reg_index,
  input  logic [31:0]                      in_write_data,
  input  logic [7:0]                       in_rx_byte,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      out_read_data,
  output logic                             out_tx_valid,
  output logic [7:0]                       out_tx_byte,
  output logic                             out_irq,
  output logic                             out_bad_access,
  // Configuration port.
  input  logic                             cfg_wr_en,
  input  logic [urfi_pkg::QSIZE_W-1:0]     cfg_wr_data
);

  // Architected registers.
  logic [urfi_pkg::QSIZE_W-1:0] qsize_r;
  logic [31:0] line_ctrl_r, line_ctrl_nxt;
  logic [31:0] uart_ctrl_r, uart_ctrl_nxt;
  logic [31:0] fifo_ctrl_r, fifo_ctrl_nxt;
  logic [31:0] modem_ctrl_r, modem_ctrl_nxt;
  logic [2:0]  trx_stat_r, trx_stat_nxt;
  logic [8:0]  fifo_stat_r, fifo_stat_nxt;
  logic [7:0]  rx_hold_r, rx_hold_nxt;
  logic [31:0] baud_div_r, baud_div_nxt;
  logic [31:0] div_slot_r, div_slot_nxt;
  logic [31:0] int_pend_r, int_pend_nxt;
  logic [31:0] int_src_r, int_src_nxt;
  logic [31:0] int_mask_r, int_mask_nxt;
  logic [urfi_pkg::FIFO_AW-1:0] rx_head_r, rx_head_nxt;
  logic [urfi_pkg::FIFO_CW-1:0] rx_count_r, rx_count_nxt;

  // Receive memory and its registered read data.
  logic [7:0] rx_mem [urfi_pkg::FIFO_SLOTS];
  logic [7:0] rx_q_r;

  // Output register.
  logic        out_valid_r;
  logic [31:0] read_data_r, read_data_nxt;
  logic        pop_sel_r;
  logic        tx_valid_r, tx_valid_nxt;
  logic [7:0]  tx_byte_r, tx_byte_nxt;
  logic        irq_r;
  logic        bad_r, bad_nxt;

  // Request decode and FIFO helpers.
  urfi_pkg::req_t               req;
  logic                         in_go;
  logic                         push;
  logic                         pop;
  logic                         upd;
  logic [urfi_pkg::CAP_W-1:0]   cap;
  logic [urfi_pkg::CAP_W-1:0]   qsize_dec;
  logic [urfi_pkg::CAP_W-1:0]   count_ext;
  logic [urfi_pkg::FIFO_CW-1:0] tail_sum;
  logic [urfi_pkg::FIFO_AW-1:0] tail;
  logic [urfi_pkg::FIFO_AW-1:0] head_inc;
  logic [31:0]                  src_upd;

  assign req      = urfi_pkg::req_t'(in_req_type);
  assign in_stall = out_valid_r && out_stall;
  assign in_go    = in_valid && !in_stall;

  // FIFO capacity: ring size minus one, limited to the storage depth.
  assign qsize_dec = urfi_pkg::CAP_W'(qsize_r) - urfi_pkg::CAP_W'(1);
  assign count_ext = urfi_pkg::CAP_W'(rx_count_r);
  always_comb begin
    if (qsize_r < urfi_pkg::QSIZE_W'(2)) begin
      cap = '0;
    end else if (qsize_dec > urfi_pkg::CAP_W'(urfi_pkg::FIFO_SLOTS)) begin
      cap = urfi_pkg::CAP_W'(urfi_pkg::FIFO_SLOTS);
    end else begin
      cap = qsize_dec;
    end
  end

  // Ring tail and next head positions.
  assign tail_sum = urfi_pkg::FIFO_CW'(rx_head_r) + rx_count_r;
  always_comb begin
    if (tail_sum >= urfi_pkg::FIFO_CW'(urfi_pkg::FIFO_SLOTS)) begin
      tail = urfi_pkg::FIFO_AW'(tail_sum - urfi_pkg::FIFO_CW'(urfi_pkg::FIFO_SLOTS));
    end else begin
      tail = urfi_pkg::FIFO_AW'(tail_sum);
    end
  end
  assign head_inc = (rx_head_r == urfi_pkg::FIFO_AW'(urfi_pkg::FIFO_SLOTS - 1)) ?
                    '0 : rx_head_r + urfi_pkg::FIFO_AW'(1);

  // Request processing: next register values and result fields.
  always_comb begin
    line_ctrl_nxt  = line_ctrl_r;
    uart_ctrl_nxt  = uart_ctrl_r;
    fifo_ctrl_nxt  = fifo_ctrl_r;
    modem_ctrl_nxt = modem_ctrl_r;
    trx_stat_nxt   = trx_stat_r;
    fifo_stat_nxt  = fifo_stat_r;
    rx_hold_nxt    = rx_hold_r;
    baud_div_nxt   = baud_div_r;
    div_slot_nxt   = div_slot_r;
    int_pend_nxt   = int_pend_r;
    int_src_nxt    = int_src_r;
    int_mask_nxt   = int_mask_r;
    rx_head_nxt    = rx_head_r;
    rx_count_nxt   = rx_count_r;
    read_data_nxt  = '0;
    tx_valid_nxt   = 1'b0;
    tx_byte_nxt    = '0;
    bad_nxt        = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    upd            = 1'b0;

    case (req)
      urfi_pkg::REQ_READ: begin
        case (in_reg_index)
          urfi_pkg::REG_LINE_CTRL:  read_data_nxt = line_ctrl_r;
          urfi_pkg::REG_UART_CTRL:  read_data_nxt = uart_ctrl_r;
          urfi_pkg::REG_FIFO_CTRL:  read_data_nxt = fifo_ctrl_r;
          urfi_pkg::REG_MODEM_CTRL: read_data_nxt = modem_ctrl_r;
          urfi_pkg::REG_TRX_STAT:   read_data_nxt = 32'(trx_stat_r);
          urfi_pkg::REG_ERR_STAT:   read_data_nxt = '0;
          urfi_pkg::REG_FIFO_STAT: begin
            fifo_stat_nxt = {count_ext >= cap, 8'(rx_count_r)};
            read_data_nxt = 32'(fifo_stat_nxt);
          end
          urfi_pkg::REG_MODEM_STAT: read_data_nxt = urfi_pkg::MODEM_STAT_VAL;
          urfi_pkg::REG_TX_DATA:    read_data_nxt = '0;
          urfi_pkg::REG_RX_DATA: begin
            if ((fifo_ctrl_r & urfi_pkg::FCTRL_EN) != '0) begin
              if (rx_count_r != '0) begin
                // Pop the head byte; the data comes from the memory read.
                pop          = 1'b1;
                rx_head_nxt  = head_inc;
                rx_count_nxt = rx_count_r - urfi_pkg::FIFO_CW'(1);
                if (rx_count_nxt == '0) begin
                  trx_stat_nxt = trx_stat_r & ~urfi_pkg::ST_READY;
                end else begin
                  trx_stat_nxt = trx_stat_r | urfi_pkg::ST_READY;
                end
              end else begin
                // Underflow raises the error interrupt.
                int_src_nxt = int_src_r | urfi_pkg::INT_ERR;
                upd         = 1'b1;
              end
            end else begin
              trx_stat_nxt  = trx_stat_r & ~urfi_pkg::ST_READY;
              read_data_nxt = 32'(rx_hold_r);
            end
          end
          urfi_pkg::REG_BAUD_DIV:   read_data_nxt = baud_div_r;
          urfi_pkg::REG_DIV_SLOT:   read_data_nxt = div_slot_r;
          urfi_pkg::REG_INT_PEND:   read_data_nxt = int_pend_r;
          urfi_pkg::REG_INT_SRC:    read_data_nxt = int_src_r;
          urfi_pkg::REG_INT_MASK:   read_data_nxt = int_mask_r;
          default:                  bad_nxt = 1'b1;
        endcase
      end
      urfi_pkg::REQ_WRITE: begin
        upd = 1'b1;
        case (in_reg_index)
          urfi_pkg::REG_LINE_CTRL:  line_ctrl_nxt = in_write_data;
          urfi_pkg::REG_UART_CTRL:  uart_ctrl_nxt = in_write_data;
          urfi_pkg::REG_FIFO_CTRL: begin
            if ((in_write_data & urfi_pkg::FCTRL_RX_RESET) != '0) begin
              rx_head_nxt  = '0;
              rx_count_nxt = '0;
            end
            fifo_ctrl_nxt = in_write_data & ~urfi_pkg::FCTRL_SC_MASK;
          end
          urfi_pkg::REG_MODEM_CTRL: modem_ctrl_nxt = in_write_data;
          urfi_pkg::REG_TRX_STAT:   ;
          urfi_pkg::REG_ERR_STAT:   ;
          urfi_pkg::REG_TX_DATA: begin
            trx_stat_nxt = trx_stat_r | urfi_pkg::ST_TXIDLE;
            int_src_nxt  = int_src_r | urfi_pkg::INT_TXD;
            tx_valid_nxt = 1'b1;
            tx_byte_nxt  = in_write_data[7:0];
          end
          urfi_pkg::REG_BAUD_DIV:   baud_div_nxt = in_write_data;
          urfi_pkg::REG_DIV_SLOT:   div_slot_nxt = in_write_data;
          urfi_pkg::REG_INT_PEND:   int_src_nxt  = int_src_r & ~in_write_data;
          urfi_pkg::REG_INT_SRC:    int_src_nxt  = in_write_data;
          urfi_pkg::REG_INT_MASK:   int_mask_nxt = in_write_data;
          default: begin
            bad_nxt = 1'b1;
            upd     = 1'b0;
          end
        endcase
      end
      urfi_pkg::REQ_RX: begin
        upd          = 1'b1;
        trx_stat_nxt = trx_stat_r | urfi_pkg::ST_READY;
        if ((fifo_ctrl_r & urfi_pkg::FCTRL_EN) != '0) begin
          // Queue the byte unless the FIFO is full; a full FIFO drops it.
          if (count_ext < cap) begin
            push         = 1'b1;
            rx_count_nxt = rx_count_r + urfi_pkg::FIFO_CW'(1);
          end
          if (rx_count_nxt != '0) begin
            int_src_nxt = int_src_r | urfi_pkg::INT_RXD;
          end
        end else begin
          rx_hold_nxt = in_rx_byte;
          int_src_nxt = int_src_r | urfi_pkg::INT_RXD;
        end
      end
      default: ;
    endcase

    // Interrupt update: TXD follows the FIFO enable, then mask.
    src_upd = int_src_nxt;
    if ((fifo_ctrl_nxt & urfi_pkg::FCTRL_EN) != '0) begin
      src_upd = int_src_nxt | urfi_pkg::INT_TXD;
    end
    if (upd) begin
      int_src_nxt  = src_upd;
      int_pend_nxt = src_upd & ~int_mask_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsize_r <= urfi_pkg::QSIZE_RESET;
    end else if (cfg_wr_en) begin
      qsize_r <= cfg_wr_data;
    end
  end

  // Register file and FIFO pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_ctrl_r  <= '0;
      uart_ctrl_r  <= '0;
      fifo_ctrl_r  <= '0;
      modem_ctrl_r <= '0;
      trx_stat_r   <= urfi_pkg::ST_RESET;
      fifo_stat_r  <= '0;
      rx_hold_r    <= '0;
      baud_div_r   <= '0;
      div_slot_r   <= '0;
      int_pend_r   <= '0;
      int_src_r    <= '0;
      int_mask_r   <= '0;
      rx_head_r    <= '0;
      rx_count_r   <= '0;
    end else if (in_go) begin
      line_ctrl_r  <= line_ctrl_nxt;
      uart_ctrl_r  <= uart_ctrl_nxt;
      fifo_ctrl_r  <= fifo_ctrl_nxt;
      modem_ctrl_r <= modem_ctrl_nxt;
      trx_stat_r   <= trx_stat_nxt;
      fifo_stat_r  <= fifo_stat_nxt;
      rx_hold_r    <= rx_hold_nxt;
      baud_div_r   <= baud_div_nxt;
      div_slot_r   <= div_slot_nxt;
      int_pend_r   <= int_pend_nxt;
      int_src_r    <= int_src_nxt;
      int_mask_r   <= int_mask_nxt;
      rx_head_r    <= rx_head_nxt;
      rx_count_r   <= rx_count_nxt;
    end
  end

  // Receive memory: write on push, registered read of the head on pop.
  always_ff @(posedge clk) begin
    if (in_go && push) begin
      rx_mem[tail] <= in_rx_byte;
    end
    if (in_go && pop) begin
      rx_q_r <= rx_mem[rx_head_r];
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_go) begin
      read_data_r <= read_data_nxt;
      pop_sel_r   <= pop;
      tx_valid_r  <= tx_valid_nxt;
      tx_byte_r   <= tx_byte_nxt;
      irq_r       <= int_pend_nxt != '0;
      bad_r       <= bad_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = pop_sel_r ? 32'(rx_q_r) : read_data_r;
  assign out_tx_valid   = tx_valid_r;
  assign out_tx_byte    = tx_byte_r;
  assign out_irq        = irq_r;
  assign out_bad_access = bad_r;

`ifndef NO_ASSERTIONS
  // The fill count never exceeds the storage depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= urfi_pkg::FIFO_CW'(urfi_pkg::FIFO_SLOTS))
    else $error("receive FIFO count beyond storage depth");

  // A pop is only issued with bytes in the FIFO.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && pop) |-> (rx_count_r != '0))
    else $error("receive FIFO popped while empty");

  // A taken request leaves a result in the output register.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> out_valid_r)
    else $error("accepted request produced no result");

  // Irq in a result agrees with the pending register after the request.
  a_irq_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> (out_irq == (int_pend_r != '0)))
    else $error("irq disagrees with pending interrupts");
`endif

endmodule

>>> tb/sv/tb_uart_regs_rx_fifo_irq_unit.sv
// Testbench for the UART register block: random and directed requests against a predictor.
`timescale 1ns / 100ps

module tb_uart_regs_rx_fifo_irq_unit;
  import urfi_pkg::*;

  // One request on the input channel.
  typedef struct packed {
    req_t        kind;
    logic [3:0]  idx;
    logic [31:0] wdata;
    logic [7:0]  rbyte;
  } uart_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic        bad_access;
  } uart_result_t;

  localparam int STUCK_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Register model of the UART block plus the queue of results it still owes.
  class uart_scoreboard;
    logic [QSIZE_W-1:0] ring_size;
    logic [31:0] line_ctrl, uart_ctrl, fifo_ctrl, modem_ctrl;
    logic [31:0] baud_div, div_slot, int_pend, int_src, int_mask;
    logic [2:0]  trx_stat;
    logic [8:0]  fifo_stat;
    logic [7:0]  rx_hold;
    logic [7:0]  rx_mem [FIFO_SLOTS];
    logic [FIFO_AW-1:0] rx_head;
    logic [FIFO_CW-1:0] rx_fill;
    uart_result_t owed_q[$];
    int failures, reports, n_requests, n_results;
    int n_tx, n_bad, n_drops, n_underflows, max_fill;

    function new();
      ring_size = QSIZE_RESET;
      line_ctrl = '0; uart_ctrl = '0; fifo_ctrl = '0; modem_ctrl = '0;
      baud_div = '0; div_slot = '0; int_pend = '0; int_src = '0; int_mask = '0;
      trx_stat = ST_RESET;
      fifo_stat = '0;
      rx_hold = '0;
      rx_head = '0;
      rx_fill = '0;
      failures = 0; reports = 0; n_requests = 0; n_results = 0;
      n_tx = 0; n_bad = 0; n_drops = 0; n_underflows = 0; max_fill = 0;
    endfunction

    function void set_ring_size(logic [QSIZE_W-1:0] v);
      ring_size = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Usable FIFO entries for the current ring size.
    function int unsigned fifo_room();
      if (ring_size < 2) return 0;
      if (ring_size - 1 > FIFO_SLOTS) return FIFO_SLOTS;
      return ring_size - 1;
    endfunction

    // The TX level is always empty, so TXD follows the FIFO enable.
    function void refresh_irq();
      if (fifo_ctrl[0]) int_src |= INT_TXD;
      int_pend = int_src & ~int_mask;
    endfunction

    // Work out the result of one accepted request and queue it.
    function void note_request(uart_req_t r);
      uart_result_t res;
      logic [FIFO_AW-1:0] tail;
      res = '0;
      n_requests++;
      case (r.kind)
        REQ_READ: begin
          case (r.idx)
            REG_LINE_CTRL:  res.read_data = line_ctrl;
            REG_UART_CTRL:  res.read_data = uart_ctrl;
            REG_FIFO_CTRL:  res.read_data = fifo_ctrl;
            REG_MODEM_CTRL: res.read_data = modem_ctrl;
            REG_TRX_STAT:   res.read_data = {29'd0, trx_stat};
            REG_ERR_STAT:   res.read_data = '0;
            REG_FIFO_STAT: begin
              fifo_stat = {rx_fill >= fifo_room(), rx_fill[7:0]};
              res.read_data = {23'd0, fifo_stat};
            end
            REG_MODEM_STAT: res.read_data = MODEM_STAT_VAL;
            REG_TX_DATA:    res.read_data = '0;
            REG_RX_DATA: begin
              if (fifo_ctrl[0]) begin
                if (rx_fill != 0) begin
                  res.read_data = {24'd0, rx_mem[rx_head]};
                  rx_head++;
                  rx_fill--;
                  if (rx_fill == 0) trx_stat &= ~ST_READY;
                  else trx_stat |= ST_READY;
                end else begin
                  // Underflow flags an error interrupt and reads zero.
                  n_underflows++;
                  int_src |= INT_ERR;
                  refresh_irq();
                end
              end else begin
                trx_stat &= ~ST_READY;
                res.read_data = {24'd0, rx_hold};
              end
            end
            REG_BAUD_DIV:   res.read_data = baud_div;
            REG_DIV_SLOT:   res.read_data = div_slot;
            REG_INT_PEND:   res.read_data = int_pend;
            REG_INT_SRC:    res.read_data = int_src;
            REG_INT_MASK:   res.read_data = int_mask;
            default:        res.bad_access = 1'b1;
          endcase
        end
        REQ_WRITE: begin
          case (r.idx)
            REG_LINE_CTRL:  line_ctrl = r.wdata;
            REG_UART_CTRL:  uart_ctrl = r.wdata;
            REG_FIFO_CTRL: begin
              if ((r.wdata & FCTRL_RX_RESET) != 0) begin
                rx_head = '0;
                rx_fill = '0;
              end
              fifo_ctrl = r.wdata & ~FCTRL_SC_MASK;
            end
            REG_MODEM_CTRL: modem_ctrl = r.wdata;
            REG_TRX_STAT, REG_ERR_STAT: ;
            REG_TX_DATA: begin
              trx_stat |= ST_TXIDLE;
              int_src |= INT_TXD;
              res.tx_valid = 1'b1;
              res.tx_byte = r.wdata[7:0];
            end
            REG_BAUD_DIV:   baud_div = r.wdata;
            REG_DIV_SLOT:   div_slot = r.wdata;
            REG_INT_PEND: begin
              int_pend &= ~r.wdata;
              int_src &= ~r.wdata;
            end
            REG_INT_SRC:    int_src = r.wdata;
            REG_INT_MASK:   int_mask = r.wdata;
            default:        res.bad_access = 1'b1;
          endcase
          if (!res.bad_access) refresh_irq();
        end
        REQ_RX: begin
          if (fifo_ctrl[0]) begin
            if (rx_fill < fifo_room()) begin
              tail = rx_head + rx_fill[FIFO_AW-1:0];
              rx_mem[tail] = r.rbyte;
              rx_fill++;
            end else begin
              n_drops++;
            end
            trx_stat |= ST_READY;
            if (rx_fill != 0) int_src |= INT_RXD;
          end else begin
            rx_hold = r.rbyte;
            int_src |= INT_RXD;
            trx_stat |= ST_READY;
          end
          refresh_irq();
        end
        default: ;
      endcase
      if (rx_fill > max_fill) max_fill = rx_fill;
      if (res.tx_valid) n_tx++;
      if (res.bad_access) n_bad++;
      res.irq = (int_pend != 0);
      owed_q.push_back(res);
    endfunction

    // Compare one delivered result with the oldest owed one.
    function void check_result(uart_result_t got);
      uart_result_t want;
      if (owed_q.size() == 0) begin
        failures++;
        reports++;
        if (reports <= MAX_REPORTS)
          $display("%0t: result with no request pending: rd=%h tx=%b/%h irq=%b bad=%b",
                   $time, got.read_data, got.tx_valid, got.tx_byte, got.irq, got.bad_access);
        return;
      end
      want = owed_q.pop_front();
      n_results++;
      if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
          got.tx_byte !== want.tx_byte || got.irq !== want.irq ||
          got.bad_access !== want.bad_access) begin
        failures++;
        reports++;
        if (reports <= MAX_REPORTS) begin
          $display("%0t: result mismatch", $time);
          $display("  expected rd=%h tx=%b/%h irq=%b bad=%b",
                   want.read_data, want.tx_valid, want.tx_byte, want.irq, want.bad_access);
          $display("  actual   rd=%h tx=%b/%h irq=%b bad=%b",
                   got.read_data, got.tx_valid, got.tx_byte, got.irq, got.bad_access);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_req_type;
  logic [3:0] in_reg_index;
  logic [31:0] in_write_data;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic out_tx_valid;
  logic [7:0] out_tx_byte;
  logic out_irq, out_bad_access;
  logic cfg_wr_en;
  logic [QSIZE_W-1:0] cfg_wr_data;

  uart_scoreboard sb;
  bit calm = 1'b0;
  int stuck_cycles = 0;

  uart_regs_rx_fifo_irq_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_reg_index   (in_reg_index),
    .in_write_data  (in_write_data),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_tx_valid   (out_tx_valid),
    .out_tx_byte    (out_tx_byte),
    .out_irq        (out_irq),
    .out_bad_access (out_bad_access),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls now and then, except during a calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 6);
  end

  // Sample both channels at the rising edge and watch for a hung block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result('{out_read_data, out_tx_valid, out_tx_byte, out_irq, out_bad_access});
      if (in_valid && !in_stall)
        sb.note_request('{req_t'(in_req_type), in_reg_index, in_write_data, in_rx_byte});
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("Timeout: no request or result moved for %0d cycles", STUCK_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Present one request, with an occasional gap before it, and wait until it is taken.
  task automatic send_request(req_t kind, logic [3:0] idx, logic [31:0] wdata,
                              logic [7:0] rbyte);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_reg_index  <= idx;
    in_write_data <= wdata;
    in_rx_byte    <= rbyte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off new requests until every owed result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write the ring size while the block is idle.
  task automatic set_ring_size(logic [QSIZE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_ring_size(v);
  endtask

  // Random request, weighted toward receive traffic and FIFO reads.
  task automatic send_random_request();
    int unsigned pick;
    logic [31:0] data;
    logic [3:0] idx;
    logic [7:0] rbyte;
    pick  = $urandom_range(99);
    data  = $urandom;
    idx   = 4'($urandom_range(15));
    rbyte = 8'($urandom);
    if (pick < 30) begin
      send_request(REQ_RX, idx, data, rbyte);
    end else if (pick < 52) begin
      send_request(REQ_READ, REG_RX_DATA, data, rbyte);
    end else if (pick < 60) begin
      send_request(REQ_READ, REG_FIFO_STAT, data, rbyte);
    end else if (pick < 75) begin
      send_request(REQ_READ, idx, data, rbyte);
    end else if (pick < 80) begin
      // FIFO control mostly keeps the FIFO on and rarely flushes it.
      data[0] = ($urandom_range(9) != 0);
      if ($urandom_range(3) != 0) data[1] = 1'b0;
      send_request(REQ_WRITE, REG_FIFO_CTRL, data, rbyte);
    end else if (pick < 84) begin
      send_request(REQ_WRITE, REG_TX_DATA, data, rbyte);
    end else if (pick < 88) begin
      send_request(REQ_WRITE, REG_INT_PEND, data, rbyte);
    end else if (pick < 97) begin
      send_request(REQ_WRITE, idx, data, rbyte);
    end else begin
      send_request(REQ_NONE, idx, data, rbyte);
    end
  endtask

  // Register extremes, every offset class, underflow, holding mode and bad offsets.
  task automatic run_directed();
    send_request(REQ_WRITE, REG_LINE_CTRL, 32'hffff_ffff, 8'h00);
    send_request(REQ_READ, REG_LINE_CTRL, 32'h0, 8'h00);
    send_request(REQ_READ, REG_MODEM_STAT, 32'h0, 8'h00);
    send_request(REQ_READ, REG_ERR_STAT, 32'h0, 8'h00);
    send_request(REQ_READ, REG_TX_DATA, 32'h0, 8'h00);
    send_request(REQ_WRITE, REG_FIFO_CTRL, 32'hffff_ffff, 8'h00);
    send_request(REQ_READ, REG_FIFO_CTRL, 32'h0, 8'h00);
    send_request(REQ_RX, REG_LINE_CTRL, 32'h0, 8'h00);
    send_request(REQ_RX, REG_LINE_CTRL, 32'h0, 8'hff);
    send_request(REQ_READ, REG_FIFO_STAT, 32'h0, 8'h00);
    send_request(REQ_READ, REG_RX_DATA, 32'h0, 8'h00);
    send_request(REQ_READ, REG_RX_DATA, 32'h0, 8'h00);
    send_request(REQ_READ, REG_RX_DATA, 32'h0, 8'h00);
    send_request(REQ_READ, REG_INT_SRC, 32'h0, 8'h00);
    send_request(REQ_WRITE, REG_INT_MASK, 32'hffff_fffe, 8'h00);
    send_request(REQ_READ, REG_INT_PEND, 32'h0, 8'h00);
    send_request(REQ_WRITE, REG_INT_PEND, 32'hffff_ffff, 8'h00);
    send_request(REQ_WRITE, REG_TX_DATA, 32'h5a5a_5aa5, 8'h00);
    send_request(REQ_WRITE, REG_TRX_STAT, 32'hffff_ffff, 8'h00);
    send_request(REQ_WRITE, REG_FIFO_STAT, 32'hffff_ffff, 8'h00);
    send_request(REQ_WRITE, REG_MODEM_STAT, 32'h0, 8'h00);
    send_request(REQ_WRITE, REG_RX_DATA, 32'h0, 8'h00);
    send_request(REQ_READ, 4'd15, 32'h0, 8'h00);
    send_request(REQ_WRITE, 4'd15, 32'hffff_ffff, 8'h00);
    send_request(REQ_NONE, 4'd15, 32'hffff_ffff, 8'hff);
    send_request(REQ_WRITE, REG_FIFO_CTRL, 32'h0, 8'h00);
    send_request(REQ_RX, REG_LINE_CTRL, 32'h0, 8'h5a);
    send_request(REQ_READ, REG_RX_DATA, 32'h0, 8'h00);
  endtask

  // Fill the largest ring past its capacity without gaps, then drain part of it.
  task automatic fill_and_drain();
    calm = 1'b1;
    send_request(REQ_WRITE, REG_FIFO_CTRL, FCTRL_EN | FCTRL_RX_RESET, 8'($urandom));
    for (int i = 0; i < 270; i++) begin
      send_request(REQ_RX, 4'($urandom), $urandom, 8'($urandom));
      if (i % 40 == 39) send_request(REQ_READ, REG_FIFO_STAT, $urandom, 8'($urandom));
    end
    send_request(REQ_READ, REG_FIFO_STAT, $urandom, 8'($urandom));
    for (int i = 0; i < 150; i++)
      send_request(REQ_READ, REG_RX_DATA, $urandom, 8'($urandom));
    calm = 1'b0;
  endtask

  // Main sequence: reset, then phases at several ring sizes.
  initial begin
    sb = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_NONE;
    in_reg_index  = '0;
    in_write_data = '0;
    in_rx_byte    = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < 6; p++) begin
      pause_until_drained();
      case (p)
        0: begin
          set_ring_size(QSIZE_RESET);
          run_directed();
          repeat (150) send_random_request();
        end
        1: begin
          set_ring_size(9'd2);
          repeat (120) send_random_request();
        end
        2: begin
          set_ring_size(9'd257);
          fill_and_drain();
        end
        3: begin
          // The ring still holds about a hundred bytes, well above this capacity.
          set_ring_size(9'd5);
          repeat (150) send_random_request();
        end
        4: begin
          set_ring_size(9'($urandom_range(3, 40)));
          repeat (120) send_random_request();
        end
        default: begin
          set_ring_size(9'($urandom_range(2, 257)));
          repeat (150) send_random_request();
        end
      endcase
    end

    pause_until_drained();
    repeat (5) @(negedge clk);
    sb.failures += sb.pending();

    $display("Run: %0d requests, %0d results checked, ring sizes 2 to 257 over six phases.",
             sb.n_requests, sb.n_results);
    $display("Seen: %0d bytes sent, %0d bad offsets, %0d dropped bytes,",
             sb.n_tx, sb.n_bad, sb.n_drops);
    $display("      %0d underflows, peak fill %0d.", sb.n_underflows, sb.max_fill);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", sb.failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
